FILE: rtl/set_assoc_cache_fifo_model_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the FIFO-replacement tag cache
// Shared property shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_FIFO_MODEL_UNIT_DEFINES_SVH
`define SET_ASSOC_CACHE_FIFO_MODEL_UNIT_DEFINES_SVH

// same-cycle implication, idle during reset
`define SACF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sacf assertion failed");

// next-cycle implication, idle during reset
`define SACF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sacf assertion failed");

`endif

FILE: rtl/sacf_pkg.sv
// ----------------------------------------------------------------------------
// sacf_pkg
// Sizes, register indexes and the set row type of the FIFO tag cache.
// ----------------------------------------------------------------------------
package sacf_pkg;

  localparam int NUM_SETS  = 256;
  localparam int WAYS      = 8;
  localparam int ADDR_BITS = 48;

  localparam int SET_W     = $clog2(NUM_SETS);
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_CNT_W = $clog2(WAYS + 1);
  localparam int TAG_W     = ADDR_BITS;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // one memory word: all ways of a set
  typedef struct packed {
    logic [WAYS-1:0]            vld;
    logic [WAYS-1:0][TAG_W-1:0] tags;
  } sacf_row_t;

endpackage

FILE: rtl/set_assoc_cache_fifo_model_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_model_unit
// Tag-only set-associative cache model with FIFO replacement and counters.
// ----------------------------------------------------------------------------
// Each access (op, address) is taken when start is high and busy is low. The
// block then holds busy for one cycle while the set row is read from the tag
// memory, searched and written back, and the next access can be taken as soon
// as busy falls; the set memory has a registered read. In the cycle in which
// busy falls, done pulses for one cycle
// with hit and the four running totals; the receiver cannot hold it off, and
// the totals stay on the ports until the next access. Configuration writes
// (cfg_we, cfg_index, cfg_data) take effect at once and belong in idle time.
// There is no clearing pass after reset: a per-set flag marks rows never
// written, and such rows read as all ways empty.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_model_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   op,
  input  logic [sacf_pkg::ADDR_BITS-1:0]         address,
  input  logic                                   cfg_we,
  input  logic [sacf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sacf_pkg::CFG_W-1:0]             cfg_data,
  output logic                                   done,
  output logic                                   hit,
  output logic [sacf_pkg::CNT_W-1:0]             hits_total,
  output logic [sacf_pkg::CNT_W-1:0]             misses_total,
  output logic [sacf_pkg::CNT_W-1:0]             mem_reads_total,
  output logic [sacf_pkg::CNT_W-1:0]             mem_writes_total
);
  import sacf_pkg::*;

  typedef enum logic {IDLE, LOOK} state_t;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  state_t state;

  // configuration
  logic [CFG_W-1:0] offset_bits;
  logic [CFG_W-1:0] set_bits;
  logic [CFG_W-1:0] ways_in_use;

  // access held across the lookup cycle
  logic             cur_op;
  logic [SET_W-1:0] cur_set;
  logic [TAG_W-1:0] cur_tag;

  // set memory and its never-written flags
  sacf_row_t        mem [NUM_SETS];
  sacf_row_t        rd_row;
  logic [NUM_SETS-1:0] row_init;

  logic             accept;
  logic [ADDR_BITS-1:0] addr_sh;
  logic [SET_W-1:0] set_mask;
  logic [SET_W-1:0] in_set;
  logic [CFG_W:0]   tag_shift;
  logic [TAG_W-1:0] in_tag;

  logic [WAY_CNT_W-1:0] n_eff;
  sacf_row_t        eff_row;
  sacf_row_t        row_next;
  logic [WAYS-1:0]  in_use;
  logic [WAYS-1:0]  match;
  logic [WAYS-1:0]  empty;
  logic [WAY_W-1:0] first_empty;
  logic             look_hit;
  logic             placed;

  assign accept = start && !busy;
  assign busy   = (state == LOOK);

  // split the address: set index above the offset, tag above both
  always_comb begin
    addr_sh = address >> offset_bits;
    if (int'(set_bits) >= SET_W) begin
      set_mask = '1;
    end else begin
      set_mask = SET_W'((SET_W+1)'(1) << set_bits) - SET_W'(1);
    end
    in_set    = addr_sh[SET_W-1:0] & set_mask;
    tag_shift = (CFG_W+1)'(offset_bits) + (CFG_W+1)'(set_bits);
    in_tag    = TAG_W'(address >> tag_shift);
  end

  // associativity clamped to 1..WAYS
  always_comb begin
    if (ways_in_use == '0) begin
      n_eff = WAY_CNT_W'(1);
    end else if (int'(ways_in_use) > WAYS) begin
      n_eff = WAY_CNT_W'(WAYS);
    end else begin
      n_eff = WAY_CNT_W'(ways_in_use);
    end
  end

  // search, fill or shift the row that was read
  always_comb begin
    eff_row     = rd_row;
    eff_row.vld = row_init[cur_set] ? rd_row.vld : '0;
    first_empty = '0;
    for (int w = 0; w < WAYS; w++) begin
      in_use[w] = (w < int'(n_eff));
      match[w]  = in_use[w] && eff_row.vld[w] && (eff_row.tags[w] == cur_tag);
      empty[w]  = in_use[w] && !eff_row.vld[w];
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (empty[w]) begin
        first_empty = WAY_W'(w);
      end
    end
    look_hit = |match;
    placed   = |empty;

    row_next = eff_row;
    if (!look_hit) begin
      if (placed) begin
        row_next.tags[first_empty] = cur_tag;
        row_next.vld[first_empty]  = 1'b1;
      end else begin
        // oldest way drops out, new tag goes last
        for (int w = 0; w < WAYS; w++) begin
          if (w + 1 < int'(n_eff)) begin
            row_next.tags[w] = eff_row.tags[w+1];
            row_next.vld[w]  = eff_row.vld[w+1];
          end else if (w + 1 == int'(n_eff)) begin
            row_next.tags[w] = cur_tag;
            row_next.vld[w]  = 1'b1;
          end
        end
      end
    end
  end

  // set memory: read on accept, write back at the end of the lookup
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row <= mem[in_set];
    end
    if (state == LOOK) begin
      mem[cur_set] <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op  <= op;
      cur_set <= in_set;
      cur_tag <= in_tag;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= CFG_W'(4);
      set_bits    <= '0;
      ways_in_use <= CFG_W'(WAYS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_BITS: offset_bits <= cfg_data;
        REG_SET_BITS:    set_bits    <= cfg_data;
        REG_WAYS_IN_USE: ways_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // control, counters and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= IDLE;
      done             <= 1'b0;
      hit              <= 1'b0;
      row_init         <= '0;
      hits_total       <= '0;
      misses_total     <= '0;
      mem_reads_total  <= '0;
      mem_writes_total <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            state <= LOOK;
          end
        end
        LOOK: begin
          state             <= IDLE;
          done              <= 1'b1;
          hit               <= look_hit;
          row_init[cur_set] <= 1'b1;
          if (cur_op == OP_WRITE && mem_writes_total != CNT_MAX) begin
            mem_writes_total <= mem_writes_total + CNT_W'(1);
          end
          if (look_hit) begin
            if (hits_total != CNT_MAX) begin
              hits_total <= hits_total + CNT_W'(1);
            end
          end else begin
            if (misses_total != CNT_MAX) begin
              misses_total <= misses_total + CNT_W'(1);
            end
            if (mem_reads_total != CNT_MAX) begin
              mem_reads_total <= mem_reads_total + CNT_W'(1);
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/sacf_checker.sv
// ----------------------------------------------------------------------------
// sacf_checker
// Port-level checks of the FIFO tag cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_fifo_model_unit_defines.svh"

module sacf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic                           hit,
  input logic [sacf_pkg::CNT_W-1:0]     hits_total,
  input logic [sacf_pkg::CNT_W-1:0]     misses_total,
  input logic [sacf_pkg::CNT_W-1:0]     mem_reads_total,
  input logic [sacf_pkg::CNT_W-1:0]     mem_writes_total
);
  import sacf_pkg::*;

  // taken word moves into the lookup
  `SACF_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // lookup always ends in exactly one result word
  `SACF_ASSERT_NEXT(a_busy_done, clk, rst, busy, done && !busy)
  // one strobe per word
  `SACF_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  // every miss costs one memory read
  `SACF_ASSERT_IMP(a_miss_reads, clk, rst, done, misses_total == mem_reads_total)
  // a hit never shows a zero hit count
  `SACF_ASSERT_IMP(a_hit_count, clk, rst, done && hit, hits_total != '0)

endmodule

bind set_assoc_cache_fifo_model_unit sacf_checker u_sacf_checker (.*);

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the FIFO-replacement tag cache
// Drives directed and random accesses across several geometry settings and
// checks hit and running totals against a tag-array predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sacf_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 130;

  typedef struct packed {
    logic                 op;
    logic [ADDR_BITS-1:0] addr;
  } access_t;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] reads;
    logic [CNT_W-1:0] writes;
  } outcome_t;

  // DUT ports
  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 op        = OP_READ;
  logic [ADDR_BITS-1:0] address   = '0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_OFFSET_BITS;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 busy;
  logic                 done;
  logic                 hit;
  logic [CNT_W-1:0]     hits_total;
  logic [CNT_W-1:0]     misses_total;
  logic [CNT_W-1:0]     mem_reads_total;
  logic [CNT_W-1:0]     mem_writes_total;

  // words waiting to go out, and outcomes waiting to come back
  access_t  pending_accesses[$];
  outcome_t expected_outcomes[$];

  // shadow of the cache: tags, valid bits, counters, geometry
  logic [ADDR_BITS-1:0] shadow_tag [NUM_SETS*WAYS];
  bit                   shadow_vld [NUM_SETS*WAYS];
  logic [CNT_W-1:0]     n_hits   = '0;
  logic [CNT_W-1:0]     n_misses = '0;
  logic [CNT_W-1:0]     n_reads  = '0;
  logic [CNT_W-1:0]     n_writes = '0;
  logic [CFG_W-1:0]     cur_off  = 4'd4;
  logic [CFG_W-1:0]     cur_sb   = 4'd0;
  logic [CFG_W-1:0]     cur_ways = 4'd8;

  logic     taken_q = 1'b0;
  int       gap_left   = 0;
  int       burst_left = 1;
  int       fail_count = 0;
  int       cycles     = 0;
  access_t  next_word;
  outcome_t got, want;

  set_assoc_cache_fifo_model_unit dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .op               (op),
    .address          (address),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .done             (done),
    .hit              (hit),
    .hits_total       (hits_total),
    .misses_total     (misses_total),
    .mem_reads_total  (mem_reads_total),
    .mem_writes_total (mem_writes_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // One access against the shadow cache; returns hit plus the totals after it.
  function automatic outcome_t cache_lookup(input logic is_wr,
                                            input logic [ADDR_BITS-1:0] a);
    logic [63:0] addr64, set_idx, tag;
    int          sh, n, base, w;
    bit          found, placed;
    outcome_t    r;
    addr64  = 64'(a);
    sh      = int'(cur_off) + int'(cur_sb);
    // set bits above the table size fold back (modulo the set count)
    set_idx = ((addr64 >> cur_off) & ((64'd1 << cur_sb) - 64'd1)) % 64'(NUM_SETS);
    tag     = (addr64 >> sh) & {16'd0, {48{1'b1}}};
    // zero ways acts as one, too many acts as all
    n = (cur_ways == 0) ? 1 : ((int'(cur_ways) > WAYS) ? WAYS : int'(cur_ways));
    base = int'(set_idx) * WAYS;
    found = 1'b0;
    placed = 1'b0;
    if (is_wr == OP_WRITE) n_writes = sat_bump(n_writes);
    for (w = 0; w < n && !found; w++)
      if (shadow_vld[base+w] && shadow_tag[base+w] == tag[ADDR_BITS-1:0]) found = 1'b1;
    if (found) begin
      n_hits = sat_bump(n_hits);
    end else begin
      n_misses = sat_bump(n_misses);
      n_reads  = sat_bump(n_reads);
      for (w = 0; w < n && !placed; w++) begin
        if (!shadow_vld[base+w]) begin
          shadow_tag[base+w] = tag[ADDR_BITS-1:0];
          shadow_vld[base+w] = 1'b1;
          placed = 1'b1;
        end
      end
      // set full: oldest way drops out, new tag goes last
      if (!placed) begin
        for (w = 1; w < n; w++) begin
          shadow_tag[base+w-1] = shadow_tag[base+w];
          shadow_vld[base+w-1] = shadow_vld[base+w];
        end
        shadow_tag[base+n-1] = tag[ADDR_BITS-1:0];
        shadow_vld[base+n-1] = 1'b1;
      end
    end
    r.hit    = found;
    r.hits   = n_hits;
    r.misses = n_misses;
    r.reads  = n_reads;
    r.writes = n_writes;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // sender holds off until every queued word went out and came back
  task automatic wait_idle();
    while (pending_accesses.size() != 0 || expected_outcomes.size() != 0 || start)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Predictor side: mirror config writes, predict each accepted word.
  always @(posedge clk) begin
    if (rst) begin
      taken_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OFFSET_BITS: cur_off  = cfg_data;
          REG_SET_BITS:    cur_sb   = cfg_data;
          REG_WAYS_IN_USE: cur_ways = cfg_data;
          default: ;
        endcase
      end
      taken_q <= start && !busy;
      if (start && !busy) expected_outcomes.push_back(cache_lookup(op, address));
    end
  end

  // Driver: inputs move on the falling edge. A word stays up until taken;
  // bursts of random length alternate with random gaps (often none).
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken_q) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_accesses.size() != 0) begin
        next_word = pending_accesses.pop_front();
        start   <= 1'b1;
        op      <= next_word.op;
        address <= next_word.addr;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each done strobe is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      got = {hit, hits_total, misses_total, mem_reads_total, mem_writes_total};
      if (expected_outcomes.size() == 0) begin
        flag_error($sformatf("ERROR: done with no access pending: hit=%b totals %0d/%0d/%0d/%0d",
                             got.hit, got.hits, got.misses, got.reads, got.writes));
      end else begin
        want = expected_outcomes.pop_front();
        if (got.hit !== want.hit || got.hits !== want.hits || got.misses !== want.misses
            || got.reads !== want.reads || got.writes !== want.writes)
          flag_error($sformatf(
            "ERROR: exp hit=%b h=%0d m=%0d r=%0d w=%0d, got hit=%b h=%0d m=%0d r=%0d w=%0d",
            want.hit, want.hits, want.misses, want.reads, want.writes,
            got.hit, got.hits, got.misses, got.reads, got.writes));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus: directed words at the reset geometry, then one random phase
  // per geometry. Cached tags carry over between phases on purpose.
  initial begin
    int          ph_off  [PHASES] = '{0, 12, 6, 2, 0, 15, 3, 4};
    int          ph_sb   [PHASES] = '{0, 8, 3, 8, 11, 2, 1, 0};
    int          ph_ways [PHASES] = '{1, 8, 4, 2, 0, 13, 8, 8};
    int          p, i, n;
    logic [63:0] tagf, setf, offf, a;
    access_t     w;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset geometry: 16-byte blocks, one set, eight ways
    pending_accesses.push_back('{OP_READ,  48'h0});            // cold miss
    pending_accesses.push_back('{OP_WRITE, 48'h0});            // hit
    pending_accesses.push_back('{OP_READ,  48'hF});            // same block, hit
    pending_accesses.push_back('{OP_WRITE, 48'hFFFF_FFFF_FFFF}); // top of range, miss
    for (i = 1; i <= 7; i++)                                    // fill, then evict oldest
      pending_accesses.push_back('{OP_READ, 48'(i << 4)});
    pending_accesses.push_back('{OP_READ,  48'h0});            // evicted, miss again
    pending_accesses.push_back('{OP_WRITE, 48'hFFFF_FFFF_FFFF});
    pending_accesses.push_back('{OP_WRITE, 48'h8000_0000_0000});
    pending_accesses.push_back('{OP_READ,  48'hAAAA_AAAA_AAAA});
    pending_accesses.push_back('{OP_WRITE, 48'h5555_5555_5555});
    wait_idle();

    for (p = 0; p < PHASES; p++) begin
      write_reg(REG_OFFSET_BITS, ph_off[p]);
      write_reg(REG_SET_BITS,    ph_sb[p]);
      write_reg(REG_WAYS_IN_USE, ph_ways[p]);
      n = (ph_ways[p] == 0) ? 1 : ((ph_ways[p] > WAYS) ? WAYS : ph_ways[p]);
      for (i = 0; i < PHASE_WORDS; i++) begin
        w.op = $urandom_range(0, 1);
        if ($urandom_range(0, 9) == 0) begin
          // fully random address, toggles every bit
          a = {$urandom, $urandom};
        end else begin
          // small tag pool per few sets: hits plus steady eviction
          tagf = $urandom_range(0, n + 2);
          if ($urandom_range(0, 15) == 0) tagf = {$urandom, $urandom};
          setf = $urandom_range(0, 3);
          if ($urandom_range(0, 4) == 0) setf = $urandom;
          // index bits past the table size alias onto low sets
          if (ph_sb[p] > 8 && $urandom_range(0, 1) == 1)
            setf = setf | (64'($urandom_range(1, 7)) << 8);
          offf = {$urandom, $urandom};
          a = (tagf << (ph_off[p] + ph_sb[p]))
            | ((setf & ((64'd1 << ph_sb[p]) - 64'd1)) << ph_off[p])
            | (offf & ((64'd1 << ph_off[p]) - 64'd1));
        end
        w.addr = a[ADDR_BITS-1:0];
        pending_accesses.push_back(w);
      end
      wait_idle();
    end

    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
